FILE: sv/tdac_pkg.sv
package tdac_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    localparam logic [1:0] POS_CLOSED = 2'd0;
    localparam logic [1:0] POS_OPEN   = 2'd1;
    localparam logic [1:0] POS_HALF   = 2'd2;
    localparam logic [1:0] POS_FAULT  = 2'd3;

    localparam logic [1:0] CMD_IDLE   = 2'd0;
    localparam logic [1:0] CMD_OPEN   = 2'd1;
    localparam logic [1:0] CMD_OPENED = 2'd2;
    localparam logic [1:0] CMD_CLOSE  = 2'd3;

    localparam logic [1:0] DRV_STOP = 2'd0;
    localparam logic [1:0] DRV_FWD  = 2'd1;
    localparam logic [1:0] DRV_REV  = 2'd2;

    localparam logic [7:0] ERR_FAULT    = 8'h01;
    localparam logic [7:0] ERR_POS_CLR  = 8'h03;
    localparam logic [7:0] ERR_CLOSE_TO = 8'h04;
    localparam logic [7:0] ERR_OPEN_TO  = 8'h08;
    localparam logic [7:0] ERR_LINK     = 8'h80;

    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TIMEOUT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_OPEN_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_SPEED_HALF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_SPEED_FULL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_SPEED_HALF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_SPEED_FULL  = 3'd6;

    localparam logic [15:0] RST_MOVE_TIMEOUT     = 16'h01E0;
    localparam logic [15:0] RST_HALF_OPEN_LIMIT  = 16'h7530;
    localparam logic [15:0] RST_PWM_PERIOD       = 16'd7200;
    localparam logic [15:0] RST_CLOSE_SPEED_HALF = 16'd5500;
    localparam logic [15:0] RST_CLOSE_SPEED_FULL = 16'd4000;
    localparam logic [15:0] RST_OPEN_SPEED_HALF  = 16'd2000;
    localparam logic [15:0] RST_OPEN_SPEED_FULL  = 16'd1400;

    typedef struct packed {
        logic       front_closed_n;
        logic       front_open_n;
        logic       rear_closed_n;
        logic       rear_open_n;
        logic       clear_key_n;
        logic       front_cmd_valid;
        logic [1:0] front_cmd;
        logic       rear_cmd_valid;
        logic [1:0] rear_cmd;
        logic       deliver_active;
        logic       link_alive;
    } req_t;

    typedef struct packed {
        logic [1:0]  front_drive;
        logic [15:0] front_compare;
        logic [1:0]  rear_drive;
        logic [15:0] rear_compare;
        logic [7:0]  error_bits;
        logic        red_led_n;
        logic        green_led_n;
        logic [1:0]  front_position;
        logic [1:0]  rear_position;
        logic [1:0]  front_command;
        logic [1:0]  rear_command;
    } rsp_t;

    typedef struct packed {
        logic [15:0] move_timeout;
        logic [15:0] half_open_limit;
        logic [15:0] pwm_period;
        logic [15:0] close_speed_half;
        logic [15:0] close_speed_full;
        logic [15:0] open_speed_half;
        logic [15:0] open_speed_full;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  drive;
        logic [15:0] compare;
        cnt_t        cnt_close_half;
        cnt_t        cnt_close_full;
        cnt_t        cnt_open_half;
        cnt_t        cnt_open_full;
        cnt_t        cnt_half_pos;
    } door_state_t;

    typedef struct packed {
        logic [1:0] position;
        logic [7:0] set_mask;
        logic [7:0] clr_mask;
        logic       alarm;
    } door_flags_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == '1) ? v : v + cnt_t'(1);
    endfunction

    function automatic logic below(input cnt_t v, input logic [15:0] limit);
        return CMP_W'(v) < CMP_W'(limit);
    endfunction

    function automatic logic [15:0] rev_compare(input logic [15:0] speed,
                                                input logic [15:0] period);
        return (speed > period) ? 16'd0 : period - speed;
    endfunction

    function automatic logic [1:0] decode_pos(input logic closed_n, input logic open_n);
        logic [1:0] p;
        unique case ({closed_n, open_n})
            2'b01:   p = POS_CLOSED;
            2'b10:   p = POS_OPEN;
            2'b11:   p = POS_HALF;
            default: p = POS_FAULT;
        endcase
        return p;
    endfunction

endpackage

FILE: sv/tdac_cfg.sv
module tdac_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tdac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                     cfg_wdata,
    output tdac_pkg::cfg_t                  cfg
);
    import tdac_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MOVE_TIMEOUT:     cfg_next.move_timeout     = cfg_wdata;
                REG_HALF_OPEN_LIMIT:  cfg_next.half_open_limit  = cfg_wdata;
                REG_PWM_PERIOD:       cfg_next.pwm_period       = cfg_wdata;
                REG_CLOSE_SPEED_HALF: cfg_next.close_speed_half = cfg_wdata;
                REG_CLOSE_SPEED_FULL: cfg_next.close_speed_full = cfg_wdata;
                REG_OPEN_SPEED_HALF:  cfg_next.open_speed_half  = cfg_wdata;
                REG_OPEN_SPEED_FULL:  cfg_next.open_speed_full  = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_timeout     <= RST_MOVE_TIMEOUT;
            cfg_reg.half_open_limit  <= RST_HALF_OPEN_LIMIT;
            cfg_reg.pwm_period       <= RST_PWM_PERIOD;
            cfg_reg.close_speed_half <= RST_CLOSE_SPEED_HALF;
            cfg_reg.close_speed_full <= RST_CLOSE_SPEED_FULL;
            cfg_reg.open_speed_half  <= RST_OPEN_SPEED_HALF;
            cfg_reg.open_speed_full  <= RST_OPEN_SPEED_FULL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/tdac_door.sv
module tdac_door (
    input  logic                  closed_n,
    input  logic                  open_n,
    input  logic                  clear_key_n,
    input  logic                  cmd_valid,
    input  logic [1:0]            cmd_in,
    input  tdac_pkg::cfg_t        cfg,
    input  tdac_pkg::door_state_t st,
    output tdac_pkg::door_state_t st_next,
    output tdac_pkg::door_flags_t flags
);
    import tdac_pkg::*;

    logic [1:0] pos;
    cnt_t       c_ch;
    cnt_t       c_cf;
    cnt_t       c_oh;
    cnt_t       c_of;
    cnt_t       c_half;

    assign pos    = decode_pos(closed_n, open_n);
    assign c_ch   = sat_inc(clear_key_n ? st.cnt_close_half : '0);
    assign c_cf   = sat_inc(clear_key_n ? st.cnt_close_full : '0);
    assign c_oh   = sat_inc(clear_key_n ? st.cnt_open_half : '0);
    assign c_of   = sat_inc(clear_key_n ? st.cnt_open_full : '0);
    assign c_half = sat_inc(st.cnt_half_pos);

    // The half-position path and the limit-switch path of one motion are
    // exclusive, so at most one of them runs before the end-stop check.
    always_comb
    begin
        st_next = st;
        flags = '0;
        flags.position = pos;
        st_next.cmd = cmd_valid ? cmd_in : st.cmd;
        if (!clear_key_n)
        begin
            st_next.cnt_close_half = '0;
            st_next.cnt_close_full = '0;
            st_next.cnt_open_half  = '0;
            st_next.cnt_open_full  = '0;
        end

        if (st_next.cmd == CMD_OPEN)
        begin
            if (pos == POS_HALF)
            begin
                st_next.cnt_open_half = c_oh;
                if (below(c_oh, cfg.move_timeout))
                begin
                    st_next.drive   = DRV_FWD;
                    st_next.compare = cfg.open_speed_half;
                end
                else
                begin
                    st_next.drive   = DRV_STOP;
                    st_next.compare = '0;
                    flags.set_mask  = ERR_OPEN_TO;
                end
            end
            if (!closed_n)
            begin
                st_next.cnt_open_full = c_of;
                if (below(c_of, cfg.move_timeout))
                begin
                    st_next.drive   = DRV_FWD;
                    st_next.compare = cfg.open_speed_full;
                end
                else
                begin
                    st_next.drive   = DRV_STOP;
                    st_next.compare = '0;
                    flags.set_mask  = ERR_OPEN_TO;
                end
            end
            if (!open_n)
            begin
                st_next.drive   = DRV_STOP;
                st_next.compare = '0;
                st_next.cmd     = CMD_OPENED;
                flags.clr_mask  = ERR_OPEN_TO;
            end
        end
        else if (st_next.cmd == CMD_CLOSE)
        begin
            if (pos == POS_HALF)
            begin
                st_next.cnt_close_half = c_ch;
                if (below(c_ch, cfg.move_timeout))
                begin
                    st_next.drive   = DRV_REV;
                    st_next.compare = rev_compare(cfg.close_speed_half, cfg.pwm_period);
                end
                else
                begin
                    st_next.drive   = DRV_STOP;
                    st_next.compare = '0;
                    flags.set_mask  = ERR_CLOSE_TO;
                end
            end
            if (!open_n)
            begin
                st_next.cnt_close_full = c_cf;
                if (below(c_cf, cfg.move_timeout))
                begin
                    st_next.drive   = DRV_REV;
                    st_next.compare = rev_compare(cfg.close_speed_full, cfg.pwm_period);
                end
                else
                begin
                    st_next.drive   = DRV_STOP;
                    st_next.compare = '0;
                    flags.set_mask  = ERR_CLOSE_TO;
                end
            end
            if (!closed_n)
            begin
                st_next.drive   = DRV_STOP;
                st_next.compare = '0;
                st_next.cmd     = CMD_IDLE;
                flags.clr_mask  = ERR_CLOSE_TO;
            end
        end

        if (pos == POS_HALF)
        begin
            st_next.cnt_half_pos = c_half;
            flags.alarm = !below(c_half, cfg.half_open_limit);
        end
        else if (pos != POS_FAULT)
        begin
            st_next.cnt_half_pos = '0;
        end
    end

endmodule

FILE: sv/two_door_actuator_controller.sv
// Path: an accepted item waits in the input register; when the output can advance,
// its result is loaded into the result register and the door state is updated.
// Throughput: one item per cycle when the output is not stalled; the input and result
// registers let a new item enter while a finished result is stalled at the output.
// Reset: all counters, commands, drive modes, compares and error bits clear to zero,
// and the configuration registers return to their documented defaults.
module two_door_actuator_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  tdac_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output tdac_pkg::rsp_t                 rsp,
    input  logic                           cfg_wr_en,
    input  logic [tdac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_wdata
);
    import tdac_pkg::*;

    cfg_t        cfg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    req_t        s1_item_reg;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    door_state_t front_reg;
    door_state_t front_next;
    door_state_t rear_reg;
    door_state_t rear_next;
    door_flags_t front_flags;
    door_flags_t rear_flags;
    logic [7:0]  err_reg;
    logic [7:0]  err_next;
    logic [7:0]  err_work;
    logic        advance;
    logic        fire;
    logic        accept;

    tdac_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tdac_door u_front (
        .closed_n    (s1_item_reg.front_closed_n),
        .open_n      (s1_item_reg.front_open_n),
        .clear_key_n (s1_item_reg.clear_key_n),
        .cmd_valid   (s1_item_reg.front_cmd_valid),
        .cmd_in      (s1_item_reg.front_cmd),
        .cfg         (cfg),
        .st          (front_reg),
        .st_next     (front_next),
        .flags       (front_flags)
    );

    tdac_door u_rear (
        .closed_n    (s1_item_reg.rear_closed_n),
        .open_n      (s1_item_reg.rear_open_n),
        .clear_key_n (s1_item_reg.clear_key_n),
        .cmd_valid   (s1_item_reg.rear_cmd_valid),
        .cmd_in      (s1_item_reg.rear_cmd),
        .cfg         (cfg),
        .st          (rear_reg),
        .st_next     (rear_next),
        .flags       (rear_flags)
    );

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = s1_valid_reg && advance;
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !fire);
    assign rsp_valid_next = fire || (rsp_valid_reg && rsp_stall);

    // Error byte: position clear, front door flags, rear door flags, then fault
    // and half alarm; the red LED samples the byte before the link bit.
    always_comb
    begin
        err_work = err_reg;
        if (front_flags.position == POS_CLOSED || front_flags.position == POS_OPEN)
        begin
            err_work = err_work & ~ERR_POS_CLR;
        end
        err_work = (err_work | front_flags.set_mask) & ~front_flags.clr_mask;
        err_work = (err_work | rear_flags.set_mask) & ~rear_flags.clr_mask;
        if (front_flags.position == POS_FAULT || rear_flags.position == POS_FAULT
            || front_flags.alarm || rear_flags.alarm)
        begin
            err_work = err_work | ERR_FAULT;
        end
        err_next = s1_item_reg.link_alive ? (err_work & ~ERR_LINK) : (err_work | ERR_LINK);

        rsp_next.front_drive    = front_next.drive;
        rsp_next.front_compare  = front_next.compare;
        rsp_next.rear_drive     = rear_next.drive;
        rsp_next.rear_compare   = rear_next.compare;
        rsp_next.error_bits     = err_next;
        rsp_next.red_led_n      = (err_work == 8'd0);
        rsp_next.green_led_n    = !s1_item_reg.deliver_active;
        rsp_next.front_position = front_flags.position;
        rsp_next.rear_position  = rear_flags.position;
        rsp_next.front_command  = front_next.cmd;
        rsp_next.rear_command   = rear_next.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            front_reg     <= '0;
            rear_reg      <= '0;
            err_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (front_reg.drive == DRV_STOP) |-> (front_reg.compare == 16'd0))
        else $error("front door stopped with a nonzero compare");

    a_rear_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rear_reg.drive == DRV_STOP) |-> (rear_reg.compare == 16'd0))
        else $error("rear door stopped with a nonzero compare");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("input stalled while the pipeline can advance");

    a_link_bit: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (rsp_reg.error_bits[7] == !$past(s1_item_reg.link_alive)))
        else $error("link error bit does not follow the item");

    a_err_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (rsp_reg.error_bits == err_reg))
        else $error("result error byte differs from the error register");

endmodule

FILE: tb/two_door_actuator_controller_tb.sv
`timescale 1ns / 100ps

module two_door_actuator_controller_tb;
    import tdac_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_TICKS = 180;
    localparam int SOAK_TICKS = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam cnt_t CNT_FULL = '1;
    localparam logic HI = 1'b1;
    localparam logic LO = 1'b0;

    // Limit switch pairs as {closed_n, open_n}.
    localparam logic [1:0] SW_CLOSED = 2'b01;
    localparam logic [1:0] SW_OPEN   = 2'b10;
    localparam logic [1:0] SW_HALF   = 2'b11;
    localparam logic [1:0] SW_BOTH   = 2'b00;

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t want;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_wdata;

    int gap_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;

    cfg_t        door_cfg;
    cnt_t        path_cnt [8];
    cnt_t        half_cnt [2];
    logic [1:0]  door_pos [2];
    logic [1:0]  door_cmd [2];
    logic [1:0]  door_drv [2];
    logic [15:0] door_cmp [2];
    logic [7:0]  err_reg;
    logic [1:0]  sw_state [2];

    rsp_t        pending_ticks [$];
    script_row_t script [$];

    two_door_actuator_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic void reset_doors();
        door_cfg.move_timeout = RST_MOVE_TIMEOUT;
        door_cfg.half_open_limit = RST_HALF_OPEN_LIMIT;
        door_cfg.pwm_period = RST_PWM_PERIOD;
        door_cfg.close_speed_half = RST_CLOSE_SPEED_HALF;
        door_cfg.close_speed_full = RST_CLOSE_SPEED_FULL;
        door_cfg.open_speed_half = RST_OPEN_SPEED_HALF;
        door_cfg.open_speed_full = RST_OPEN_SPEED_FULL;
        foreach (path_cnt[i])
            path_cnt[i] = '0;
        for (int d = 0; d < 2; d++)
        begin
            half_cnt[d] = '0;
            door_pos[d] = POS_CLOSED;
            door_cmd[d] = CMD_IDLE;
            door_drv[d] = DRV_STOP;
            door_cmp[d] = '0;
        end
        err_reg = '0;
    endfunction

    function automatic cnt_t bump(input cnt_t v);
        return (v == CNT_FULL) ? v : v + 1'b1;
    endfunction

    function automatic void set_drive(input int d, input logic [1:0] mode,
                                      input logic [15:0] speed);
        door_drv[d] = mode;
        if (mode == DRV_FWD)
            door_cmp[d] = speed;
        else if (mode == DRV_REV)
            door_cmp[d] = (speed > door_cfg.pwm_period) ? 16'd0 : door_cfg.pwm_period - speed;
        else
            door_cmp[d] = '0;
    endfunction

    function automatic void timed_path(input int d, input int ci, input logic [1:0] mode,
                                       input logic [15:0] speed, input logic [7:0] flag);
        path_cnt[ci] = bump(path_cnt[ci]);
        if (path_cnt[ci] < door_cfg.move_timeout)
            set_drive(d, mode, speed);
        else
        begin
            set_drive(d, DRV_STOP, '0);
            err_reg |= flag;
        end
    endfunction

    function automatic void door_move(input int d, input logic closed_n, input logic open_n,
                                      input bit opening);
        int          base;
        logic [1:0]  mode;
        logic [7:0]  flag;
        logic [15:0] from_half;
        logic [15:0] from_end;
        logic        start_n;
        logic        target_n;
        base = opening ? 4 + 2 * d : 2 * d;
        mode = opening ? DRV_FWD : DRV_REV;
        flag = opening ? ERR_OPEN_TO : ERR_CLOSE_TO;
        from_half = opening ? door_cfg.open_speed_half : door_cfg.close_speed_half;
        from_end = opening ? door_cfg.open_speed_full : door_cfg.close_speed_full;
        start_n = opening ? closed_n : open_n;
        target_n = opening ? open_n : closed_n;
        if (door_pos[d] == POS_HALF)
            timed_path(d, base, mode, from_half, flag);
        if (!start_n)
            timed_path(d, base + 1, mode, from_end, flag);
        if (!target_n)
        begin
            set_drive(d, DRV_STOP, '0);
            door_cmd[d] = opening ? CMD_OPENED : CMD_IDLE;
            err_reg &= ~flag;
        end
    endfunction

    function automatic logic [1:0] switch_position(input logic closed_n, input logic open_n);
        case ({closed_n, open_n})
            SW_CLOSED: return POS_CLOSED;
            SW_OPEN:   return POS_OPEN;
            SW_HALF:   return POS_HALF;
            default:   return POS_FAULT;
        endcase
    endfunction

    // One control tick of both doors; returns what the block should report for it.
    function automatic rsp_t advance_doors(input req_t r);
        logic closed_n [2];
        logic open_n [2];
        logic red_n;
        rsp_t o;
        closed_n[0] = r.front_closed_n;
        open_n[0] = r.front_open_n;
        closed_n[1] = r.rear_closed_n;
        open_n[1] = r.rear_open_n;
        if (r.front_cmd_valid)
            door_cmd[0] = r.front_cmd;
        if (r.rear_cmd_valid)
            door_cmd[1] = r.rear_cmd;
        for (int d = 0; d < 2; d++)
            door_pos[d] = switch_position(closed_n[d], open_n[d]);
        if (door_pos[0] == POS_CLOSED || door_pos[0] == POS_OPEN)
            err_reg &= ~ERR_POS_CLR;
        if (!r.clear_key_n)
            foreach (path_cnt[i])
                path_cnt[i] = '0;
        for (int d = 0; d < 2; d++)
        begin
            if (door_cmd[d] == CMD_OPEN)
                door_move(d, closed_n[d], open_n[d], 1'b1);
            else if (door_cmd[d] == CMD_CLOSE)
                door_move(d, closed_n[d], open_n[d], 1'b0);
        end
        if (door_pos[0] == POS_FAULT || door_pos[1] == POS_FAULT)
            err_reg |= ERR_FAULT;
        for (int d = 0; d < 2; d++)
        begin
            if (door_pos[d] == POS_HALF)
            begin
                half_cnt[d] = bump(half_cnt[d]);
                if (half_cnt[d] >= door_cfg.half_open_limit)
                    err_reg |= ERR_FAULT;
            end
            else if (door_pos[d] != POS_FAULT)
                half_cnt[d] = '0;
        end
        red_n = (err_reg == 8'h00);
        if (!r.link_alive)
            err_reg |= ERR_LINK;
        else
            err_reg &= ~ERR_LINK;
        o.front_drive = door_drv[0];
        o.front_compare = door_cmp[0];
        o.rear_drive = door_drv[1];
        o.rear_compare = door_cmp[1];
        o.error_bits = err_reg;
        o.red_led_n = red_n;
        o.green_led_n = !r.deliver_active;
        o.front_position = door_pos[0];
        o.rear_position = door_pos[1];
        o.front_command = door_cmd[0];
        o.rear_command = door_cmd[1];
        return o;
    endfunction

    function automatic req_t tick_req(input logic [1:0] front_sw, input logic [1:0] rear_sw,
                                      input logic clr_n, input logic fv, input logic [1:0] fc,
                                      input logic rv, input logic [1:0] rc,
                                      input logic deliver, input logic link);
        req_t t;
        {t.front_closed_n, t.front_open_n} = front_sw;
        {t.rear_closed_n, t.rear_open_n} = rear_sw;
        t.clear_key_n = clr_n;
        t.front_cmd_valid = fv;
        t.front_cmd = fc;
        t.rear_cmd_valid = rv;
        t.rear_cmd = rc;
        t.deliver_active = deliver;
        t.link_alive = link;
        return t;
    endfunction

    function automatic rsp_t idle_rsp(input logic [7:0] err, input logic red_n,
                                      input logic green_n, input logic [1:0] front_pos,
                                      input logic [1:0] rear_pos);
        rsp_t o;
        o.front_drive = DRV_STOP;
        o.front_compare = '0;
        o.rear_drive = DRV_STOP;
        o.rear_compare = '0;
        o.error_bits = err;
        o.red_led_n = red_n;
        o.green_led_n = green_n;
        o.front_position = front_pos;
        o.rear_position = rear_pos;
        o.front_command = CMD_IDLE;
        o.rear_command = CMD_IDLE;
        return o;
    endfunction

    function automatic logic [1:0] drift(input logic [1:0] cur);
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return cur;
        if (r < 90)
        begin
            if (cur == SW_HALF)
                return $urandom_range(1) ? SW_OPEN : SW_CLOSED;
            return SW_HALF;
        end
        return 2'($urandom_range(3));
    endfunction

    // Mostly doors that travel between their end stops under occasional commands;
    // one item in ten is raw noise.
    function automatic req_t random_tick();
        logic [31:0] bits32;
        req_t        t;
        bits32 = $urandom();
        t = bits32[$bits(req_t)-1:0];
        if ($urandom_range(99) < 10)
            return t;
        sw_state[0] = drift(sw_state[0]);
        sw_state[1] = drift(sw_state[1]);
        {t.front_closed_n, t.front_open_n} = sw_state[0];
        {t.rear_closed_n, t.rear_open_n} = sw_state[1];
        t.clear_key_n = ($urandom_range(99) >= 4);
        t.front_cmd_valid = ($urandom_range(99) < 12);
        t.rear_cmd_valid = ($urandom_range(99) < 12);
        t.link_alive = ($urandom_range(99) >= 8);
        if ($urandom_range(4) != 0)
            t.front_cmd = $urandom_range(1) ? CMD_OPEN : CMD_CLOSE;
        if ($urandom_range(4) != 0)
            t.rear_cmd = $urandom_range(1) ? CMD_OPEN : CMD_CLOSE;
        return t;
    endfunction

    task automatic add_row(input req_t item, input bit typed, input rsp_t want);
        script_row_t row;
        row.item = item;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endtask

    task automatic send_tick(input req_t item, input bit typed, input rsp_t typed_rsp);
        rsp_t model_rsp;
        bit   taken;
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
        begin
            @(posedge clk);
            taken = !req_stall;
            @(negedge clk);
        end
        while (!taken);
        model_rsp = advance_doors(item);
        pending_ticks.push_back(typed ? typed_rsp : model_rsp);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        case (idx)
            REG_MOVE_TIMEOUT:     door_cfg.move_timeout = val;
            REG_HALF_OPEN_LIMIT:  door_cfg.half_open_limit = val;
            REG_PWM_PERIOD:       door_cfg.pwm_period = val;
            REG_CLOSE_SPEED_HALF: door_cfg.close_speed_half = val;
            REG_CLOSE_SPEED_FULL: door_cfg.close_speed_full = val;
            REG_OPEN_SPEED_HALF:  door_cfg.open_speed_half = val;
            REG_OPEN_SPEED_FULL:  door_cfg.open_speed_full = val;
            default: ;
        endcase
    endtask

    // The unused index is written too; the block must ignore it.
    task automatic load_config(input cfg_t c);
        put_reg(REG_MOVE_TIMEOUT, c.move_timeout);
        put_reg(REG_HALF_OPEN_LIMIT, c.half_open_limit);
        put_reg(REG_PWM_PERIOD, c.pwm_period);
        put_reg(REG_CLOSE_SPEED_HALF, c.close_speed_half);
        put_reg(REG_CLOSE_SPEED_FULL, c.close_speed_full);
        put_reg(REG_OPEN_SPEED_HALF, c.open_speed_half);
        put_reg(REG_OPEN_SPEED_FULL, c.open_speed_full);
        put_reg(REG_UNUSED, 16'($urandom()));
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input cfg_t c, input int gap, input int stall);
        load_config(c);
        gap_pct = gap;
        stall_pct = stall;
        repeat (PHASE_TICKS) send_tick(random_tick(), 1'b0, '0);
        drain();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin : check_ticks
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_ticks.size() == 0)
            begin
                $error("result with no item outstanding: %h", rsp);
                mismatch_count++;
            end
            else
            begin
                want = pending_ticks.pop_front();
                check_field("front_drive", 32'(want.front_drive), 32'(rsp.front_drive));
                check_field("front_compare", 32'(want.front_compare),
                            32'(rsp.front_compare));
                check_field("rear_drive", 32'(want.rear_drive), 32'(rsp.rear_drive));
                check_field("rear_compare", 32'(want.rear_compare), 32'(rsp.rear_compare));
                check_field("error_bits", 32'(want.error_bits), 32'(rsp.error_bits));
                check_field("red_led_n", 32'(want.red_led_n), 32'(rsp.red_led_n));
                check_field("green_led_n", 32'(want.green_led_n), 32'(rsp.green_led_n));
                check_field("front_position", 32'(want.front_position),
                            32'(rsp.front_position));
                check_field("rear_position", 32'(want.rear_position),
                            32'(rsp.rear_position));
                check_field("front_command", 32'(want.front_command),
                            32'(rsp.front_command));
                check_field("rear_command", 32'(want.rear_command), 32'(rsp.rear_command));
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("two_door_actuator_controller_tb: done, errors");
        $finish;
    end

    initial
    begin
        cfg_t setting;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        reset_doors();
        sw_state[0] = SW_CLOSED;
        sw_state[1] = SW_CLOSED;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_row(tick_req(SW_CLOSED, SW_CLOSED, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b1,
                idle_rsp(8'h00, 1'b1, 1'b1, POS_CLOSED, POS_CLOSED));
        add_row(tick_req(SW_BOTH, SW_CLOSED, HI, LO, CMD_IDLE, LO, CMD_IDLE, HI, HI), 1'b1,
                idle_rsp(ERR_FAULT, 1'b0, 1'b0, POS_FAULT, POS_CLOSED));
        add_row(tick_req(SW_CLOSED, SW_CLOSED, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, LO), 1'b1,
                idle_rsp(ERR_LINK, 1'b1, 1'b1, POS_CLOSED, POS_CLOSED));
        add_row(tick_req(SW_CLOSED, SW_CLOSED, HI, HI, CMD_OPEN, LO, CMD_IDLE, HI, HI), 1'b0, '0);
        add_row(tick_req(SW_HALF, SW_CLOSED, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_OPEN, SW_CLOSED, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_OPEN, SW_CLOSED, HI, HI, CMD_CLOSE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_HALF, SW_CLOSED, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_CLOSED, SW_CLOSED, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_CLOSED, SW_CLOSED, HI, LO, CMD_IDLE, HI, CMD_OPEN, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_CLOSED, SW_HALF, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_CLOSED, SW_OPEN, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_CLOSED, SW_OPEN, HI, LO, CMD_IDLE, HI, CMD_CLOSE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_CLOSED, SW_HALF, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_CLOSED, SW_BOTH, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_CLOSED, SW_CLOSED, HI, LO, CMD_IDLE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_BOTH, SW_CLOSED, HI, HI, CMD_OPEN, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_BOTH, SW_CLOSED, HI, HI, CMD_CLOSE, LO, CMD_IDLE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_HALF, SW_HALF, LO, HI, CMD_OPEN, HI, CMD_CLOSE, LO, HI), 1'b0, '0);
        add_row(tick_req(SW_HALF, SW_HALF, HI, HI, CMD_OPENED, HI, CMD_IDLE, HI, HI), 1'b0, '0);
        add_row(tick_req(SW_HALF, SW_HALF, HI, LO, CMD_IDLE, LO, CMD_OPENED, HI, LO), 1'b0, '0);
        foreach (script[i])
            send_tick(script[i].item, script[i].typed, script[i].want);
        drain();

        setting = {16'd3, 16'd5, RST_PWM_PERIOD, 16'($urandom_range(7200)),
                   16'($urandom_range(7200)), 16'($urandom_range(7200)),
                   16'($urandom_range(7200))};
        run_phase(setting, 0, 0);
        setting = {16'd1, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        run_phase(setting, 68, 0);
        setting = {16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
        run_phase(setting, 0, 68);
        setting = {16'd6, 16'd12, 16'($urandom_range(300, 1)), 16'($urandom_range(300)),
                   16'($urandom_range(300)), 16'($urandom_range(300)),
                   16'($urandom_range(300))};
        run_phase(setting, 10, 10);
        setting = {16'($urandom_range(20, 2)), 16'($urandom_range(40, 2)), 16'($urandom()),
                   16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
        run_phase(setting, 0, 68);

        // Both doors sit half open under a motion command with the widest limits.
        setting = {16'hFFFF, 16'hFFFF, RST_PWM_PERIOD, RST_CLOSE_SPEED_HALF,
                   RST_CLOSE_SPEED_FULL, RST_OPEN_SPEED_HALF, RST_OPEN_SPEED_FULL};
        load_config(setting);
        gap_pct = 0;
        stall_pct = 0;
        for (int n = 0; n < SOAK_TICKS; n++)
            send_tick(tick_req(SW_HALF, SW_HALF, n != 0, 1'b1, CMD_OPEN, 1'b1, CMD_CLOSE,
                               1'($urandom_range(1)), 1'($urandom_range(1))), 1'b0, '0);
        drain();

        if (mismatch_count == 0 && pending_ticks.size() == 0)
            $display("two_door_actuator_controller_tb: done, clean");
        else
            $display("two_door_actuator_controller_tb: done, errors");
        $finish;
    end

endmodule

FILE: two_door_actuator_controller.f
sv/tdac_pkg.sv
sv/tdac_cfg.sv
sv/tdac_door.sv
sv/two_door_actuator_controller.sv
tb/two_door_actuator_controller_tb.sv
